@@ design/md_tag_segment_parser_core_macros.svh @@
// Assertion macros shared by the checker of the MD tag segment parser.
// No dependencies; included by files that hold concurrent assertions.
`ifndef MD_TAG_SEGMENT_PARSER_CORE_MACROS_SVH
`define MD_TAG_SEGMENT_PARSER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is held low.
`define MTSP_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held low.
`define MTSP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/mtsp_pkg.sv @@
// Shared types and constants of the MD tag segment parser.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package mtsp_pkg;

    localparam int CHAR_W  = 8;
    localparam int LEN_W   = 32;
    localparam int KIND_W  = 2;
    localparam int TDATA_W = LEN_W + CHAR_W;

    localparam logic [LEN_W-1:0] LEN_MAX = '1;

    localparam logic [KIND_W-1:0] KIND_MATCH    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_MISMATCH = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DELETION = 2'd2;
    localparam logic [KIND_W-1:0] KIND_ERROR    = 2'd3;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [LEN_W-1:0]  length;
        logic [CHAR_W-1:0] base;
        logic              eot;
    } seg_t;

    // One queue entry holds every segment caused by one character.
    typedef struct packed {
        logic two;
        seg_t seg1;
        seg_t seg0;
    } entry_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

endpackage

@@ design/md_tag_segment_parser_core.sv @@
// Top level of the MD tag segment parser: front end, entry queue and
// segment emitter. Depends on mtsp_pkg, mtsp_front, mtsp_queue, mtsp_back.
//
//  channel | direction | tdata (low bit up)                      | tuser    | tlast
//  s_      | in        | md_char[7:0]                            | -        | last_char
//  m_      | out       | seg_length[31:0], mismatch_base[39:32]  | seg_kind | end_of_tag
//
// One character is taken every cycle while the four-entry queue has room.
// A character that closes two segments holds the output for two transfers,
// so the result port, not the parser, sets the rate on such input.
// A segment passes through the entry queue and then the output register before it is valid on m_.
// Reset, sampled at a clock edge, puts the parser in its idle state and empties the queue.
`timescale 1ns / 1ps

module md_tag_segment_parser_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // md_char[7:0]
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [mtsp_pkg::TDATA_W-1:0]  m_tdata,   // seg_length[31:0], mismatch_base[39:32]
    output logic [mtsp_pkg::KIND_W-1:0]   m_tuser,   // seg_kind[1:0]
    output logic                          m_tlast
);
    import mtsp_pkg::*;

    q_status_t q_status;
    entry_t    push_entry, head_entry;
    logic      push, pop;

    mtsp_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .q_status   (q_status),
        .push       (push),
        .push_entry (push_entry)
    );

    mtsp_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head_entry (head_entry),
        .q_status   (q_status)
    );

    mtsp_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_entry (head_entry),
        .q_status   (q_status),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

@@ design/mtsp_front.sv @@
// Front end of the MD tag segment parser: tokenises characters and builds
// queue entries. Depends on mtsp_pkg.
`timescale 1ns / 1ps

module mtsp_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,
    input  logic                 s_tlast,
    input  mtsp_pkg::q_status_t  q_status,
    output logic                 push,
    output mtsp_pkg::entry_t     push_entry
);
    import mtsp_pkg::*;

    localparam logic [2:0] MODE_IDLE = 3'd0;
    localparam logic [2:0] MODE_NUM  = 3'd1;
    localparam logic [2:0] MODE_DEL  = 3'd2;
    localparam logic [2:0] MODE_LET  = 3'd3;
    localparam logic [2:0] MODE_ERR  = 3'd4;

    localparam logic [CHAR_W-1:0] CH_CARET = 8'h5E;
    localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UZ    = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LZ    = 8'h7A;

    logic [2:0]        mode_reg, mode_next;
    logic [LEN_W-1:0]  run_reg, run_next;
    logic              lone_reg, lone_next;
    logic [CHAR_W-1:0] letter_reg, letter_next;

    logic              accept;
    logic              is_digit, is_letter, is_caret;
    logic [3:0]        digit;
    logic [LEN_W+3:0]  times_ten;
    logic [LEN_W-1:0]  acc_sat, inc_sat;
    logic              v1, v2, v3;
    seg_t              e1, e2, e3;
    seg_t              seg0, seg1;
    logic [1:0]        n_segs;

    assign s_tready  = !q_status.full;
    assign accept    = s_tvalid && s_tready;
    assign is_digit  = (s_tdata >= CH_0) && (s_tdata <= CH_9);
    assign is_letter = ((s_tdata >= CH_UA) && (s_tdata <= CH_UZ))
                    || ((s_tdata >= CH_LA) && (s_tdata <= CH_LZ));
    assign is_caret  = (s_tdata == CH_CARET);
    assign digit     = 4'(s_tdata - CH_0);

    // run * 10 + digit as two shifts and adds, saturated to the length width.
    assign times_ten = ({4'b0, run_reg} << 3) + ({4'b0, run_reg} << 1)
                     + {{LEN_W{1'b0}}, digit};
    assign acc_sat   = (times_ten[LEN_W+3:LEN_W] != 4'b0) ? LEN_MAX
                                                          : times_ten[LEN_W-1:0];
    assign inc_sat   = (run_reg == LEN_MAX) ? LEN_MAX : run_reg + LEN_W'(1);

    always_comb begin
        logic flush_old;
        logic start_new;
        flush_old   = 1'b0;
        start_new   = 1'b0;
        mode_next   = mode_reg;
        run_next    = run_reg;
        lone_next   = lone_reg;
        letter_next = letter_reg;
        v1 = 1'b0;
        v2 = 1'b0;
        v3 = 1'b0;
        e1 = '0;
        e2 = '0;
        e3 = '0;

        unique case (mode_reg)
            MODE_NUM: begin
                if (is_digit) begin
                    run_next  = acc_sat;
                    lone_next = 1'b0;
                end else begin
                    flush_old = 1'b1;
                    start_new = 1'b1;
                end
            end
            MODE_DEL: begin
                if (is_letter) begin
                    run_next = inc_sat;
                end else begin
                    flush_old = 1'b1;
                    start_new = 1'b1;
                end
            end
            MODE_LET: begin
                if (is_letter) begin
                    // Two letters in a row: the pending mismatch is dropped.
                    v2          = 1'b1;
                    e2.kind     = KIND_ERROR;
                    mode_next   = MODE_ERR;
                    letter_next = '0;
                end else begin
                    flush_old = 1'b1;
                    start_new = 1'b1;
                end
            end
            MODE_ERR: begin
            end
            default: begin
                start_new = 1'b1;
            end
        endcase

        if (flush_old) begin
            if (mode_reg == MODE_NUM) begin
                v1        = !lone_reg;
                e1.kind   = KIND_MATCH;
                e1.length = run_reg;
            end else if (mode_reg == MODE_DEL) begin
                v1        = 1'b1;
                e1.kind   = KIND_DELETION;
                e1.length = run_reg;
            end else begin
                v1        = 1'b1;
                e1.kind   = KIND_MISMATCH;
                e1.length = LEN_W'(1);
                e1.base   = letter_reg;
            end
            mode_next   = MODE_IDLE;
            run_next    = '0;
            lone_next   = 1'b0;
            letter_next = '0;
        end

        if (start_new) begin
            if (is_caret) begin
                mode_next = MODE_DEL;
                run_next  = '0;
            end else if (is_digit) begin
                mode_next = MODE_NUM;
                run_next  = {{(LEN_W-4){1'b0}}, digit};
                lone_next = (s_tdata == CH_0);
            end else if (is_letter) begin
                mode_next   = MODE_LET;
                letter_next = s_tdata;
            end else begin
                v2        = 1'b1;
                e2.kind   = KIND_ERROR;
                mode_next = MODE_ERR;
            end
        end

        // The final character closes whatever token is still open.
        if (s_tlast) begin
            if (mode_next == MODE_NUM) begin
                v3        = !lone_next;
                e3.kind   = KIND_MATCH;
                e3.length = run_next;
            end else if (mode_next == MODE_DEL) begin
                v3        = 1'b1;
                e3.kind   = KIND_DELETION;
                e3.length = run_next;
            end else if (mode_next == MODE_LET) begin
                v3        = 1'b1;
                e3.kind   = KIND_MISMATCH;
                e3.length = LEN_W'(1);
                e3.base   = letter_next;
            end
            mode_next   = MODE_IDLE;
            run_next    = '0;
            lone_next   = 1'b0;
            letter_next = '0;
        end
    end

    // At most two of the three candidates are ever valid together.
    assign n_segs = 2'(v1) + 2'(v2) + 2'(v3);

    always_comb begin
        seg0 = v1 ? e1 : (v2 ? e2 : e3);
        seg1 = v3 ? e3 : e2;
        if (n_segs == 2'd2) begin
            seg1.eot = s_tlast;
        end else begin
            seg0.eot = s_tlast;
        end
        push_entry.two  = (n_segs == 2'd2);
        push_entry.seg0 = seg0;
        push_entry.seg1 = seg1;
    end

    assign push = accept && (n_segs != 2'd0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_IDLE;
            run_reg    <= '0;
            lone_reg   <= 1'b0;
            letter_reg <= '0;
        end else if (accept) begin
            mode_reg   <= mode_next;
            run_reg    <= run_next;
            lone_reg   <= lone_next;
            letter_reg <= letter_next;
        end
    end

endmodule

@@ design/mtsp_queue.sv @@
// Short entry queue between the parser front end and the segment emitter.
// Depends on mtsp_pkg.
`timescale 1ns / 1ps

module mtsp_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  mtsp_pkg::entry_t     push_entry,
    input  logic                 pop,
    output mtsp_pkg::entry_t     head_entry,
    output mtsp_pkg::q_status_t  q_status
);
    import mtsp_pkg::*;

    entry_t            slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              do_push, do_pop;

    assign q_status.empty = (cnt_reg == '0);
    assign q_status.full  = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign do_push        = push && !q_status.full;
    assign do_pop         = pop && !q_status.empty;
    assign head_entry     = slot_reg[rd_ptr_reg];

    always_comb begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

@@ design/mtsp_back.sv @@
// Back end of the MD tag segment parser: serialises queue entries into
// single segment transfers through an output register. Depends on mtsp_pkg.
`timescale 1ns / 1ps

module mtsp_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  mtsp_pkg::entry_t              head_entry,
    input  mtsp_pkg::q_status_t           q_status,
    output logic                          pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [mtsp_pkg::TDATA_W-1:0]  m_tdata,
    output logic [mtsp_pkg::KIND_W-1:0]   m_tuser,
    output logic                          m_tlast
);
    import mtsp_pkg::*;

    logic m_tvalid_reg, m_tvalid_next;
    logic sel_reg, sel_next;
    seg_t out_seg_reg;
    logic load, take;

    // The output register may be refilled when empty or being drained.
    assign load = !m_tvalid_reg || m_tready;
    assign take = load && !q_status.empty;
    assign pop  = take && (sel_reg || !head_entry.two);

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        sel_next      = sel_reg;
        if (load) begin
            m_tvalid_next = !q_status.empty;
        end
        if (take) begin
            sel_next = pop ? 1'b0 : 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
            sel_reg      <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
            sel_reg      <= sel_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            out_seg_reg <= sel_reg ? head_entry.seg1 : head_entry.seg0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_seg_reg.base, out_seg_reg.length};
    assign m_tuser  = out_seg_reg.kind;
    assign m_tlast  = out_seg_reg.eot;

endmodule

@@ design/mtsp_checker.sv @@
// Port-level checks of the MD tag segment parser, bound to the top level.
// Depends on mtsp_pkg and md_tag_segment_parser_core_macros.svh.
`timescale 1ns / 1ps
`include "md_tag_segment_parser_core_macros.svh"

module mtsp_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [7:0]                    s_tdata,
    input logic                          s_tlast,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [mtsp_pkg::TDATA_W-1:0]  m_tdata,
    input logic [mtsp_pkg::KIND_W-1:0]   m_tuser,
    input logic                          m_tlast
);
    import mtsp_pkg::*;

    // An error segment carries neither a length nor a letter.
    `MTSP_ASSERT_NOW(a_error_empty, aclk, aresetn, m_tvalid && (m_tuser == KIND_ERROR), m_tdata == '0, "error segment with non-zero payload")

    // A mismatch is one base long and carries its letter.
    `MTSP_ASSERT_NOW(a_mismatch_shape, aclk, aresetn, m_tvalid && (m_tuser == KIND_MISMATCH), (m_tdata[LEN_W-1:0] == LEN_W'(1)) && (m_tdata[TDATA_W-1:LEN_W] != '0), "malformed mismatch segment")

    // Match and deletion segments carry no letter.
    `MTSP_ASSERT_NOW(a_no_base, aclk, aresetn, m_tvalid && ((m_tuser == KIND_MATCH) || (m_tuser == KIND_DELETION)), m_tdata[TDATA_W-1:LEN_W] == '0, "letter on a match or deletion")

    // A stalled transfer keeps its payload.
    `MTSP_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result changed")

endmodule

bind md_tag_segment_parser_core mtsp_checker u_mtsp_checker (.*);
